// ===== src/ptb_pkg.sv =====
package ptb_pkg;

	// Bank size and counter width
	localparam int TIMER_COUNT = 8;
	localparam int COUNT_WIDTH = 24;

	// Width of a timer address, and of the widened input index used for range checks
	localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
	localparam int SEL_W = ((IDX_W + 1) > 3) ? (IDX_W + 1) : 3;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [IDX_W-1:0]       slot_t;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_STOP  = 2'd1,
		CMD_POLL  = 2'd2,
		CMD_TICK  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_TICK = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	// Write request into the count and period store
	typedef struct packed {
		slot_t  addr;
		logic   count_en;
		logic   period_en;
		count_t count;
		count_t period;
	} wr_req_t;

endpackage

// ===== src/ptb_store.sv =====
module ptb_store import ptb_pkg::*; (
	input  logic    clk,
	input  wr_req_t wr,
	input  slot_t   rd_addr,
	output count_t  rd_count,
	output count_t  rd_period
);

	count_t count_mem [TIMER_COUNT];
	count_t period_mem [TIMER_COUNT];
	count_t rd_count_q;
	count_t rd_period_q;

	// Write the addressed entry
	always_ff @(posedge clk) begin
		if (wr.count_en) begin
			count_mem[wr.addr] <= wr.count;
		end
		if (wr.period_en) begin
			period_mem[wr.addr] <= wr.period;
		end
	end

	// Read one entry a cycle, data registered
	always_ff @(posedge clk) begin
		rd_count_q  <= count_mem[rd_addr];
		rd_period_q <= period_mem[rd_addr];
	end

	assign rd_count  = rd_count_q;
	assign rd_period = rd_period_q;

endmodule

// ===== src/ptb_step_unit.sv =====
module ptb_step_unit import ptb_pkg::*; (
	input  count_t count_in,
	input  count_t period_in,
	output count_t count_next,
	output logic   reached
);

	// Advance the count and compare it against the period
	assign count_next = count_in + count_t'(1);
	assign reached    = (count_next >= period_in);

endmodule

// ===== src/polled_timer_bank.sv =====
// Bank of TIMER_COUNT polled millisecond timers.
// Input channel (in_valid / in_stall) carries one item: command, timer_index,
// period_ms. Output channel (out_valid / out_stall) returns one item per
// input item with the single field expired.
// Start, stop and poll are handled in the accepting cycle; their result is
// loaded into the output register from ST_DONE, once that register is free.
// A tick walks the bank through one shared increment-and-compare unit, one
// timer a cycle against a registered read of the count/period store, so its
// result is loaded into the output register from ST_DONE after the last timer.
// in_stall is high from acceptance until the result has been loaded into the
// output register, so a new item is not accepted before that load, but it
// may be accepted while the previous result still waits in that register.
// While the receiver stalls, the result holds in the output register and a
// finished item waits in its last state until that register frees up.
// Reset clears every timer's active and expired flags and empties the output
// register; counts and periods need no reset as they are only read for
// active timers, which start has loaded.
module polled_timer_bank import ptb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [2:0]  timer_index,
	input  logic [23:0] period_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        expired
);

	state_t                 state_q;
	slot_t                  sweep_q;
	logic [TIMER_COUNT-1:0] active_q;
	logic [TIMER_COUNT-1:0] expd_q;
	logic                   res_q;
	logic                   out_valid_q;
	logic                   out_exp_q;

	logic [SEL_W-1:0] idx_wide;
	logic             in_range;
	slot_t            slot;
	cmd_t             cmd;
	logic             accept;
	logic             poll_hit;
	logic             slot_free;
	logic             live;
	logic             last;
	wr_req_t          wr;
	slot_t            rd_addr;
	count_t           rd_count;
	count_t           rd_period;
	count_t           count_next;
	logic             reached;

	// Decode the item
	assign idx_wide  = SEL_W'(timer_index);
	assign in_range  = (idx_wide < SEL_W'(TIMER_COUNT));
	assign slot      = idx_wide[IDX_W-1:0];
	assign cmd       = cmd_t'(command);
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign poll_hit  = in_range && active_q[slot] && expd_q[slot];
	assign slot_free = !out_valid_q || !out_stall;
	assign live      = active_q[sweep_q] && !expd_q[sweep_q];
	assign last      = (sweep_q == slot_t'(TIMER_COUNT - 1));

	ptb_store u_store (
		.clk       (clk),
		.wr        (wr),
		.rd_addr   (rd_addr),
		.rd_count  (rd_count),
		.rd_period (rd_period)
	);

	ptb_step_unit u_step (
		.count_in   (rd_count),
		.period_in  (rd_period),
		.count_next (count_next),
		.reached    (reached)
	);

	// Drive store writes and the read address
	always_comb begin
		wr.addr      = slot;
		wr.count_en  = 1'b0;
		wr.period_en = 1'b0;
		wr.count     = '0;
		wr.period    = count_t'(period_ms);
		rd_addr      = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd == CMD_START && in_range) begin
					wr.count_en  = 1'b1;
					wr.period_en = 1'b1;
				end else if (accept && cmd == CMD_POLL && poll_hit) begin
					wr.count_en = 1'b1;
				end
			end
			ST_TICK: begin
				wr.addr     = sweep_q;
				wr.count    = count_next;
				wr.count_en = live;
				rd_addr     = sweep_q + slot_t'(1);
			end
			default: begin
			end
		endcase
	end

	// Sequence the item and hold the per-timer flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			sweep_q  <= '0;
			active_q <= '0;
			expd_q   <= '0;
			res_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_q   <= 1'b0;
						state_q <= ST_DONE;
						case (cmd)
							CMD_START: begin
								if (in_range) begin
									active_q[slot] <= 1'b1;
									expd_q[slot]   <= 1'b0;
								end
							end
							CMD_STOP: begin
								if (in_range) begin
									active_q[slot] <= 1'b0;
									expd_q[slot]   <= 1'b0;
								end
							end
							CMD_POLL: begin
								if (poll_hit) begin
									expd_q[slot] <= 1'b0;
									res_q        <= 1'b1;
								end
							end
							CMD_TICK: begin
								sweep_q <= '0;
								state_q <= ST_TICK;
							end
							default: begin
							end
						endcase
					end
				end
				ST_TICK: begin
					if (live && reached) begin
						expd_q[sweep_q] <= 1'b1;
					end
					if (last) begin
						state_q <= ST_DONE;
					end else begin
						sweep_q <= sweep_q + slot_t'(1);
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && slot_free) begin
			out_exp_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign expired   = out_exp_q;

	// An inactive timer never carries an expired flag
	a_flag_needs_active: assert property (@(posedge clk) disable iff (!arst_n)
		(expd_q & ~active_q) == '0)
		else $error("expired flag set on inactive timer");

	// An accepted tick starts the sweep at the first timer
	a_tick_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_TICK) |=> (state_q == ST_TICK && sweep_q == '0))
		else $error("tick did not start the sweep");

	// A tick always reports not expired
	a_tick_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TICK) |-> !res_q)
		else $error("tick carries an expired result");

endmodule
